/* rtl/tbmd_pkg.sv */
package tbmd_pkg;

  localparam int POWER_BITS      = 24;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int DURATION_BITS   = 24;

  localparam int TIME_W   = 63;
  localparam int RATIO_W  = 16;
  localparam int ALPHA_W  = 16;
  localparam int MINP_W   = 24;
  localparam int GATE_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int NOISE_W  = POWER_BITS + ALPHA_FRAC_BITS;
  localparam int MUL_A_W  = NOISE_W + 1;
  localparam int MUL_B_W  = ((RATIO_W > ALPHA_W) ? RATIO_W : ALPHA_W) + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int XU_W     = NOISE_W + RATIO_W;
  localparam int TH_SHIFT = ALPHA_FRAC_BITS + 8;
  localparam int TH_HI_W  = XU_W - TH_SHIFT;
  localparam int STEPQ_W  = PROD_W - ALPHA_FRAC_BITS;
  localparam int STEP_W   = 4;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_START  = 3'd1,
    EV_MARKER = 3'd2,
    EV_SHORT  = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_ALPHA = 3'd0,
    REG_ON_RATIO    = 3'd1,
    REG_OFF_RATIO   = 3'd2,
    REG_MIN_POWER   = 3'd3,
    REG_GATE_MIN    = 3'd4,
    REG_GATE_MAX    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]     time_us;
    logic [POWER_BITS-1:0] power;
  } in_item_t;

  typedef struct packed {
    event_t                   event_res;
    logic                     tone_active;
    logic [TIME_W-1:0]        edge_time;
    logic [DURATION_BITS-1:0] tone_len;
    logic [POWER_BITS-1:0]    tone_peak;
  } out_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [RATIO_W-1:0] start_ratio;
    logic [RATIO_W-1:0] stop_ratio;
    logic [MINP_W-1:0]  power_floor;
    logic [GATE_W-1:0]  gate_min_duration;
    logic [GATE_W-1:0]  gate_max_duration;
  } cfg_regs_t;

  // microprogram steps
  typedef enum logic [STEP_W-1:0] {
    STEP_FETCH     = 4'd0,
    STEP_SEED      = 4'd1,
    STEP_TRACK_MUL = 4'd2,
    STEP_TRACK_UPD = 4'd3,
    STEP_ON_MUL    = 4'd4,
    STEP_ON_TEST   = 4'd5,
    STEP_TONE_MUL  = 4'd6,
    STEP_TONE_TEST = 4'd7,
    STEP_EMIT      = 4'd8
  } step_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_DISPATCH,
    COND_ENDED,
    COND_END_NOW,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_TRACK,
    MUL_ON,
    MUL_OFF
  } mul_sel_t;

  typedef struct packed {
    cond_t    cond;
    step_t    target;
    mul_sel_t mul;
    logic     fetch;
    logic     seed;
    logic     track_upd;
    logic     on_test;
    logic     tone_prep;
    logic     off_test;
    logic     emit;
  } ctrl_t;

  typedef struct packed {
    logic in_tone;
    logic seeded;
    logic ended;
    logic end_now;
    logic out_free;
  } stat_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '{cond: COND_NEXT, target: STEP_FETCH, mul: MUL_NONE, default: 1'b0};
    case (s)
      STEP_FETCH: begin
        c.cond  = COND_DISPATCH;
        c.fetch = 1'b1;
      end
      STEP_SEED: begin
        c.cond   = COND_JUMP;
        c.target = STEP_ON_MUL;
        c.seed   = 1'b1;
      end
      STEP_TRACK_MUL: begin
        c.mul = MUL_TRACK;
      end
      STEP_TRACK_UPD: begin
        c.cond      = COND_ENDED;
        c.target    = STEP_EMIT;
        c.track_upd = 1'b1;
      end
      STEP_ON_MUL: begin
        c.mul = MUL_ON;
      end
      STEP_ON_TEST: begin
        c.cond    = COND_JUMP;
        c.target  = STEP_EMIT;
        c.on_test = 1'b1;
      end
      STEP_TONE_MUL: begin
        c.mul       = MUL_OFF;
        c.tone_prep = 1'b1;
      end
      STEP_TONE_TEST: begin
        c.cond     = COND_END_NOW;
        c.target   = STEP_TRACK_MUL;
        c.off_test = 1'b1;
      end
      STEP_EMIT: begin
        c.cond   = COND_OUT_FREE;
        c.target = STEP_FETCH;
        c.emit   = 1'b1;
      end
      default: begin
        c.cond   = COND_JUMP;
        c.target = STEP_FETCH;
      end
    endcase
    return c;
  endfunction

endpackage

/* rtl/tbmd_cfg.sv */
module tbmd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [tbmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tbmd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output tbmd_pkg::cfg_regs_t                regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.alpha             <= tbmd_pkg::ALPHA_W'(655);
      regs.start_ratio       <= tbmd_pkg::RATIO_W'(1024);
      regs.stop_ratio        <= tbmd_pkg::RATIO_W'(512);
      regs.power_floor       <= tbmd_pkg::MINP_W'(16);
      regs.gate_min_duration <= tbmd_pkg::GATE_W'(500000);
      regs.gate_max_duration <= tbmd_pkg::GATE_W'(1100000);
    end else if (cfg_valid) begin
      case (tbmd_pkg::reg_idx_t'(cfg_index))
        tbmd_pkg::REG_NOISE_ALPHA: regs.alpha       <= cfg_data[tbmd_pkg::ALPHA_W-1:0];
        tbmd_pkg::REG_ON_RATIO:    regs.start_ratio <= cfg_data[tbmd_pkg::RATIO_W-1:0];
        tbmd_pkg::REG_OFF_RATIO:   regs.stop_ratio  <= cfg_data[tbmd_pkg::RATIO_W-1:0];
        tbmd_pkg::REG_MIN_POWER:   regs.power_floor <= cfg_data[tbmd_pkg::MINP_W-1:0];
        tbmd_pkg::REG_GATE_MIN:    regs.gate_min_duration <= cfg_data[tbmd_pkg::GATE_W-1:0];
        tbmd_pkg::REG_GATE_MAX:    regs.gate_max_duration <= cfg_data[tbmd_pkg::GATE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tbmd_seq.sv */
module tbmd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  tbmd_pkg::stat_t     stat,
  output tbmd_pkg::ctrl_t     ctrl,
  output logic                in_ready
);

  tbmd_pkg::step_t step, step_next;
  tbmd_pkg::step_t step_inc;

  assign step_inc = tbmd_pkg::step_t'(step + tbmd_pkg::STEP_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tbmd_pkg::STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

  // control word for the current step; take nothing while in reset
  always_comb begin
    ctrl     = tbmd_pkg::ucode(step);
    in_ready = ctrl.fetch && !rst;
  end

  always_comb begin
    step_next = step;
    case (ctrl.cond)
      tbmd_pkg::COND_NEXT: step_next = step_inc;
      tbmd_pkg::COND_JUMP: step_next = ctrl.target;
      tbmd_pkg::COND_DISPATCH: begin
        if (!in_valid) begin
          step_next = step;
        end else if (stat.in_tone) begin
          step_next = tbmd_pkg::STEP_TONE_MUL;
        end else if (!stat.seeded) begin
          step_next = tbmd_pkg::STEP_SEED;
        end else begin
          step_next = tbmd_pkg::STEP_TRACK_MUL;
        end
      end
      tbmd_pkg::COND_ENDED:    step_next = stat.ended ? ctrl.target : step_inc;
      tbmd_pkg::COND_END_NOW:  step_next = stat.end_now ? ctrl.target : step_inc;
      tbmd_pkg::COND_OUT_FREE: step_next = stat.out_free ? ctrl.target : step;
      default:                 step_next = tbmd_pkg::STEP_FETCH;
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken while an item is in progress");

  a_hold_to_emit: assert property (@(posedge clk) disable iff (rst)
    (step == tbmd_pkg::STEP_TONE_TEST && !stat.end_now) |=> step == tbmd_pkg::STEP_EMIT)
    else $error("tone continuation did not go to emit");

endmodule

/* rtl/tbmd_dp.sv */
module tbmd_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  tbmd_pkg::ctrl_t        ctrl,
  input  tbmd_pkg::cfg_regs_t    regs,
  input  logic                   in_valid,
  input  tbmd_pkg::in_item_t     in_data,
  output tbmd_pkg::stat_t        stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tbmd_pkg::out_item_t    out_data
);

  localparam int NW = tbmd_pkg::NOISE_W;
  localparam int FB = tbmd_pkg::ALPHA_FRAC_BITS;
  localparam int PB = tbmd_pkg::POWER_BITS;
  localparam int TW = tbmd_pkg::TIME_W;
  localparam int DB = tbmd_pkg::DURATION_BITS;

  logic [TW-1:0]  time_r;
  logic [PB-1:0]  power_r;
  logic [NW-1:0]  noise, noise_next;
  logic           seeded;
  logic           in_tone;
  logic           ended;
  logic [PB-1:0]  peak;
  logic [TW-1:0]  start_time;
  logic [TW:0]    diff_r;

  logic signed [tbmd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tbmd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [tbmd_pkg::PROD_W-1:0]  prod;

  logic signed [tbmd_pkg::STEPQ_W-1:0] step_q;
  logic signed [tbmd_pkg::STEPQ_W:0]   sum;
  logic [tbmd_pkg::XU_W-1:0]           xu;
  logic [tbmd_pkg::TH_HI_W-1:0]        th_hi;
  logic                                start_now;
  logic                                end_now;

  logic                borrow;
  logic [TW-1:0]       dlen;
  logic                dlen_big;
  logic [DB-1:0]       dur_sat;
  tbmd_pkg::event_t    gate_ev;

  tbmd_pkg::event_t    ev_r;
  logic [TW-1:0]       edge_r;
  logic [DB-1:0]       dur_r;
  logic [PB-1:0]       pk_r;

  logic                accept;
  logic                out_free;

  assign accept   = in_valid && ctrl.fetch;
  assign out_free = !out_valid || out_ready;

  // shared multiplier operands
  always_comb begin
    mul_a = $signed({1'b0, noise});
    mul_b = $signed({1'b0, regs.start_ratio});
    case (ctrl.mul)
      tbmd_pkg::MUL_TRACK: begin
        mul_a = $signed({1'b0, power_r, {FB{1'b0}}}) - $signed({1'b0, noise});
        mul_b = $signed({1'b0, regs.alpha});
      end
      tbmd_pkg::MUL_ON:  mul_b = $signed({1'b0, regs.start_ratio});
      tbmd_pkg::MUL_OFF: mul_b = $signed({1'b0, regs.stop_ratio});
      default: ;
    endcase
  end

  // noise update: floor division of the signed product, clamped to range
  always_comb begin
    step_q = $signed(prod[tbmd_pkg::PROD_W-1:FB]);
    sum    = $signed({{(tbmd_pkg::STEPQ_W-NW){1'b0}}, noise}) + step_q;
    if (sum[tbmd_pkg::STEPQ_W]) begin
      noise_next = '0;
    end else if (|sum[tbmd_pkg::STEPQ_W-1:NW]) begin
      noise_next = '1;
    end else begin
      noise_next = sum[NW-1:0];
    end
  end

  // threshold compares against the exact product
  assign xu        = prod[tbmd_pkg::XU_W-1:0];
  assign th_hi     = xu[tbmd_pkg::XU_W-1:tbmd_pkg::TH_SHIFT];
  assign start_now = (th_hi < {{(tbmd_pkg::TH_HI_W-PB){1'b0}}, power_r})
                     && (power_r > regs.power_floor);
  assign end_now   = ({{(tbmd_pkg::XU_W-PB-tbmd_pkg::TH_SHIFT){1'b0}}, power_r,
                       {tbmd_pkg::TH_SHIFT{1'b0}}} < xu)
                     || ({power_r, 1'b0} < {1'b0, regs.power_floor});

  // duration gate
  always_comb begin
    borrow   = diff_r[TW];
    dlen     = diff_r[TW-1:0];
    dlen_big = |dlen[TW-1:DB];
    dur_sat  = dlen_big ? '1 : dlen[DB-1:0];
    if (borrow) begin
      dur_sat = '0;
      gate_ev = tbmd_pkg::EV_SHORT;
    end else if (dlen < {{(TW-tbmd_pkg::GATE_W){1'b0}}, regs.gate_min_duration}) begin
      gate_ev = tbmd_pkg::EV_SHORT;
    end else if (dlen > {{(TW-tbmd_pkg::GATE_W){1'b0}}, regs.gate_max_duration}) begin
      gate_ev = tbmd_pkg::EV_LONG;
    end else begin
      gate_ev = tbmd_pkg::EV_MARKER;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul != tbmd_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (accept) begin
      time_r  <= in_data.time_us;
      power_r <= in_data.power;
      ev_r    <= tbmd_pkg::EV_NONE;
      edge_r  <= '0;
      dur_r   <= '0;
      pk_r    <= '0;
    end
    if (ctrl.tone_prep) begin
      diff_r <= {1'b0, time_r} - {1'b0, start_time};
    end
    if (ctrl.on_test && start_now) begin
      ev_r <= tbmd_pkg::EV_START;
    end
    if (ctrl.off_test && end_now) begin
      ev_r   <= gate_ev;
      edge_r <= start_time;
      dur_r  <= dur_sat;
      pk_r   <= peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise      <= '0;
      seeded     <= 1'b0;
      in_tone    <= 1'b0;
      ended      <= 1'b0;
      peak       <= '0;
      start_time <= '0;
    end else begin
      if (accept) begin
        ended <= 1'b0;
      end
      if (ctrl.seed) begin
        noise  <= {power_r, {FB{1'b0}}};
        seeded <= 1'b1;
      end
      if (ctrl.track_upd) begin
        noise <= noise_next;
      end
      if (ctrl.on_test && start_now) begin
        in_tone    <= 1'b1;
        start_time <= time_r;
        peak       <= power_r;
      end
      if (ctrl.tone_prep && (power_r > peak)) begin
        peak <= power_r;
      end
      if (ctrl.off_test && end_now) begin
        in_tone <= 1'b0;
        ended   <= 1'b1;
      end
    end
  end

  // result register: hold until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      out_data.event_res   <= ev_r;
      out_data.tone_active <= in_tone;
      out_data.edge_time   <= edge_r;
      out_data.tone_len    <= dur_r;
      out_data.tone_peak   <= pk_r;
    end
  end

  always_comb begin
    stat.in_tone  = in_tone;
    stat.seeded   = seeded;
    stat.ended    = ended;
    stat.end_now  = end_now;
    stat.out_free = out_free;
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (ctrl.off_test && end_now) |=> (!in_tone && ended))
    else $error("tone end did not clear the tone flag");

  a_ended_event: assert property (@(posedge clk) disable iff (rst)
    ended |-> (ev_r == tbmd_pkg::EV_MARKER || ev_r == tbmd_pkg::EV_SHORT
               || ev_r == tbmd_pkg::EV_LONG))
    else $error("ended tone without a gate event");

  a_start_sets: assert property (@(posedge clk) disable iff (rst)
    (ctrl.on_test && start_now) |=> (in_tone && ev_r == tbmd_pkg::EV_START))
    else $error("tone start not recorded");

endmodule

/* rtl/tone_burst_marker_detector.sv */
// Tone burst marker detector.
// Input channel (in_valid/in_ready/in_data): one timestamped power sample per
// transfer. Output channel (out_valid/out_ready/out_data): exactly one result
// per sample, in order. Configuration channel (cfg_valid/cfg_ready/cfg_index/
// cfg_data): ready whenever rst is low; write only while no sample is in progress.
// A nine-step microprogram drives one shared 41 x 17 signed multiplier. After the
// fetch step in which a sample is transferred, a continuing tone runs TONE_MUL,
// TONE_TEST; the first sample after reset SEED, ON_MUL, ON_TEST; a noise-tracking
// sample TRACK_MUL, TRACK_UPD, ON_MUL, ON_TEST; a tone end TONE_MUL, TONE_TEST,
// TRACK_MUL, TRACK_UPD. Each then ends in EMIT, where the result register loads;
// out_valid rises as EMIT is left, and in_ready rises again at the same time.
// The result sits in an output register: the next sample is taken while it
// waits. If the receiver stalls with a result still waiting, the sequencer
// holds at its emit step until the register frees.
// Reset (rst, synchronous) restores the register defaults, clears the tone
// and noise state, and empties the output register; in_ready and cfg_ready
// stay low while rst is high. The first sample after reset seeds the noise floor.
module tone_burst_marker_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tbmd_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tbmd_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tbmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tbmd_pkg::cfg_regs_t regs;
  tbmd_pkg::ctrl_t     ctrl;
  tbmd_pkg::stat_t     stat;

  assign cfg_ready = !rst;

  tbmd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  tbmd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  tbmd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .regs      (regs),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* bench/tone_burst_marker_detector_tb.sv */
`timescale 1ns / 1ps

module tone_burst_marker_detector_tb;
  import tbmd_pkg::*;

  localparam logic [63:0] NOISE_CEIL = (64'd1 << NOISE_W) - 64'd1;
  localparam logic [63:0] DUR_CEIL   = (64'd1 << DURATION_BITS) - 64'd1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [POWER_BITS-1:0] POWER_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  // Tracks the detector state, queues the result each accepted sample
  // should produce, and compares results as they leave the block.
  class marker_scoreboard;
    logic [ALPHA_W-1:0] alpha;
    logic [RATIO_W-1:0] start_ratio, stop_ratio;
    logic [MINP_W-1:0]  power_floor;
    logic [GATE_W-1:0]  gate_min, gate_max;
    bit                 in_tone, seeded;
    logic [63:0]        noise_fp, peak, tone_start;
    out_item_t          expected_q[$];
    int                 errors, samples, n_start, n_marker, n_short, n_long;

    function new();
      alpha       = 16'd655;
      start_ratio = 16'd1024;
      stop_ratio  = 16'd512;
      power_floor = 24'd16;
      gate_min    = 24'd500000;
      gate_max    = 24'd1100000;
      in_tone     = 1'b0;
      seeded      = 1'b0;
      noise_fp    = '0;
      peak        = '0;
      tone_start  = '0;
      errors      = 0;
      samples     = 0;
      n_start     = 0;
      n_marker    = 0;
      n_short     = 0;
      n_long      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_NOISE_ALPHA: alpha       = d[ALPHA_W-1:0];
        REG_ON_RATIO:    start_ratio = d[RATIO_W-1:0];
        REG_OFF_RATIO:   stop_ratio  = d[RATIO_W-1:0];
        REG_MIN_POWER:   power_floor = d[MINP_W-1:0];
        REG_GATE_MIN:    gate_min    = d[GATE_W-1:0];
        REG_GATE_MAX:    gate_max    = d[GATE_W-1:0];
        default: ;
      endcase
    endfunction

    // Exponential average towards p, floored, clamped to the Q24.16 range
    function void follow_noise(logic [63:0] p);
      logic [63:0] scaled, prod, delta;
      scaled = p << ALPHA_FRAC_BITS;
      if (scaled >= noise_fp) begin
        prod  = (scaled - noise_fp) * alpha;
        delta = prod >> ALPHA_FRAC_BITS;
        noise_fp = (delta > NOISE_CEIL - noise_fp) ? NOISE_CEIL : noise_fp + delta;
      end else begin
        prod  = (noise_fp - scaled) * alpha;
        delta = (prod >> ALPHA_FRAC_BITS) + (prod[ALPHA_FRAC_BITS-1:0] != '0);
        noise_fp = (delta > noise_fp) ? 64'd0 : noise_fp - delta;
      end
    endfunction

    function logic [63:0] noise_threshold(logic [RATIO_W-1:0] ratio, output bit inexact);
      logic [63:0] prod;
      prod = noise_fp * ratio;
      inexact = prod[TH_SHIFT-1:0] != '0;
      return prod >> TH_SHIFT;
    endfunction

    function void note_sample(in_item_t s);
      out_item_t   e;
      logic [63:0] t, p, th, span, sat;
      bit          inexact;
      t = 64'(s.time_us);
      p = 64'(s.power);
      e = '0;
      e.event_res = EV_NONE;
      if (!in_tone) begin
        if (!seeded) begin
          noise_fp = p << ALPHA_FRAC_BITS;
          seeded   = 1'b1;
        end else begin
          follow_noise(p);
        end
        th = noise_threshold(start_ratio, inexact);
        if (p > th && p > 64'(power_floor)) begin
          in_tone     = 1'b1;
          tone_start  = t;
          peak        = p;
          e.event_res = EV_START;
        end
      end else begin
        if (p > peak) peak = p;
        th = noise_threshold(stop_ratio, inexact);
        // end test rounds the threshold up, so compare against its ceiling
        if (p < th + 64'(inexact) || 2 * p < 64'(power_floor)) begin
          in_tone = 1'b0;
          e.edge_time = tone_start[TIME_W-1:0];
          e.tone_peak = peak[POWER_BITS-1:0];
          if (t < tone_start) begin
            e.event_res = EV_SHORT;
          end else begin
            span = t - tone_start;
            sat  = (span > DUR_CEIL) ? DUR_CEIL : span;
            e.tone_len = sat[DURATION_BITS-1:0];
            if (span < 64'(gate_min))      e.event_res = EV_SHORT;
            else if (span > 64'(gate_max)) e.event_res = EV_LONG;
            else                           e.event_res = EV_MARKER;
          end
          follow_noise(p);
        end
      end
      e.tone_active = in_tone;
      case (e.event_res)
        EV_START:  n_start++;
        EV_MARKER: n_marker++;
        EV_SHORT:  n_short++;
        EV_LONG:   n_long++;
        default: ;
      endcase
      expected_q.push_back(e);
      samples++;
    endfunction

    function void mismatch(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.event_res !== e.event_res)
        mismatch("event_res", 64'(e.event_res), 64'(got.event_res));
      if (got.tone_active !== e.tone_active)
        mismatch("tone_active", 64'(e.tone_active), 64'(got.tone_active));
      if (got.edge_time !== e.edge_time)
        mismatch("edge_time", 64'(e.edge_time), 64'(got.edge_time));
      if (got.tone_len !== e.tone_len)
        mismatch("tone_len", 64'(e.tone_len), 64'(got.tone_len));
      if (got.tone_peak !== e.tone_peak)
        mismatch("tone_peak", 64'(e.tone_peak), 64'(got.tone_peak));
    endfunction
  endclass

  logic                  clk, rst;
  logic                  in_valid, in_ready;
  in_item_t              in_data;
  logic                  out_valid, out_ready;
  out_item_t             out_data;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  marker_scoreboard  sb = new();
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                stall_request = 0;
  int                n_settings = 0;
  logic [TIME_W-1:0] now_us = '0;

  tone_burst_marker_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin : result_side
    int hold;
    hold = 0;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        hold = stall_request;
        stall_request = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) sb.check_result(out_data);
    end
  end

  task automatic send_sample(logic [TIME_W-1:0] t, logic [POWER_BITS-1:0] p);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{time_us: t, power: p};
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_sample(in_data);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(logic [15:0] a, logic [15:0] on_r, logic [15:0] off_r,
                              logic [23:0] min_p, logic [23:0] g_min, logic [23:0] g_max);
    write_reg(REG_NOISE_ALPHA, 24'(a));
    write_reg(REG_ON_RATIO, 24'(on_r));
    write_reg(REG_OFF_RATIO, 24'(off_r));
    write_reg(REG_MIN_POWER, min_p);
    write_reg(REG_GATE_MIN, g_min);
    write_reg(REG_GATE_MAX, g_max);
    // unmapped index must leave everything alone
    write_reg($urandom_range(1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, 24'($urandom));
    n_settings++;
  endtask

  task automatic randomize_regs();
    logic [15:0] a, on_r, off_r;
    logic [23:0] min_p, g_min, g_max;
    case ($urandom_range(5))
      0:       a = '1;
      1:       a = '0;
      default: a = 16'($urandom_range(1000, 65535));
    endcase
    case ($urandom_range(9))
      0:       on_r = '0;
      1:       on_r = '1;
      default: on_r = 16'($urandom_range(300, 4096));
    endcase
    case ($urandom_range(9))
      0:       off_r = '0;
      1:       off_r = '1;
      default: off_r = 16'($urandom_range(32, 600));
    endcase
    min_p = ($urandom_range(11) == 0) ? '1 : 24'($urandom_range(0, 64));
    g_min = ($urandom_range(7) == 0) ? '0 : 24'($urandom_range(0, 400));
    g_max = ($urandom_range(7) == 0) ? '1 : g_min + 24'($urandom_range(0, 800));
    program_regs(a, on_r, off_r, min_p, g_min, g_max);
  endtask

  // Quiet lead-in, loud stretch, then usually a drop that should close the tone
  task automatic play_burst();
    int                    quiet_n, loud_n, stride;
    logic [POWER_BITS-1:0] floor_p, peak_p;
    logic [63:0]           loud;
    quiet_n = $urandom_range(1, 6);
    loud_n  = $urandom_range(1, 20);
    stride  = $urandom_range(1, 60);
    floor_p = 24'($urandom_range(1, 1 << $urandom_range(2, 18)));
    loud    = 64'(floor_p) * 64'($urandom_range(12, 64)) + 64'd64;
    if (loud > 64'(POWER_MAX)) loud = 64'(POWER_MAX);
    peak_p  = loud[POWER_BITS-1:0];
    if ($urandom_range(9) == 0) now_us = TIME_W'({$urandom, $urandom});
    repeat (quiet_n) begin
      now_us += TIME_W'(stride);
      send_sample(now_us, 24'($urandom_range(floor_p / 2, floor_p)));
    end
    repeat (loud_n) begin
      case ($urandom_range(31))
        0:       now_us -= TIME_W'($urandom_range(1, 5000));
        1:       now_us += TIME_W'($urandom) << 8;
        default: now_us += TIME_W'(stride);
      endcase
      send_sample(now_us, 24'($urandom_range(peak_p - peak_p / 4, peak_p)));
    end
    // leave some tones running into the next burst
    if ($urandom_range(7) != 0) begin
      now_us += TIME_W'(stride);
      send_sample(now_us, 24'($urandom_range(0, floor_p / 8)));
    end
  endtask

  task automatic play_noise();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(3) == 0) now_us = TIME_W'({$urandom, $urandom});
      else                        now_us += TIME_W'($urandom_range(1, 100));
      send_sample(now_us, 24'($urandom));
    end
  endtask

  task automatic run_batch(int n);
    int target;
    target = sb.samples + n;
    while (sb.samples < target) begin
      if ($urandom_range(6) == 0) play_noise();
      else                        play_burst();
    end
    drain();
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Default registers: seed, marker, short, long, saturating, backwards time
    send_sample('0, '0);
    send_sample(TIME_W'(10), 24'd100);
    send_sample(TIME_W'(600010), POWER_MAX);
    send_sample(TIME_W'(600020), '0);
    send_sample(TIME_W'(700000), 24'd5000);
    send_sample(TIME_W'(800000), 24'd3);
    send_sample(TIME_W'(900000), 24'd5000);
    send_sample(TIME_W'(2900000), 24'd3);
    send_sample(TIME_W'(3000000), 24'd5000);
    send_sample(TIME_MAX, '0);
    send_sample(TIME_MAX, POWER_MAX);
    send_sample(TIME_W'(5), '0);
    send_sample(TIME_W'(64'h5555_5555_5555_5555), 24'h555555);
    send_sample(TIME_W'(64'h2AAA_AAAA_AAAA_AAAA), 24'hAAAAAA);
    drain();

    program_regs('1, '0, '1, '0, '0, '1);
    send_sample(TIME_W'(64'h2AAA_AAAA_AAAA_AAAA), POWER_MAX);
    send_sample(TIME_W'(64'h2AAA_AAAA_AAAA_AAAB), POWER_MAX);
    send_sample(TIME_W'(64'h2AAA_AAAA_AAAA_AAAC), '0);
    send_sample(TIME_W'(64'h5555_5555_5555_5555), 24'd1);
    drain();

    program_regs('0, '1, '0, '1, '1, '1);
    send_sample(TIME_W'(64'h5555_5555_5555_5556), POWER_MAX);
    send_sample(TIME_W'(64'h5555_5555_5555_5557), 24'd1);
    send_sample(TIME_MAX, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int b = 0; b < 3; b++) begin
        randomize_regs();
        // hold the result side off while samples keep coming
        if (ph == 0 && b == 1) stall_request = 200;
        run_batch(150);
      end
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d samples across %0d register settings, idle/stall phases",
             sb.samples, n_settings);
    $display("Tone starts %0d, markers %0d, short rejects %0d, long rejects %0d",
             sb.n_start, sb.n_marker, sb.n_short, sb.n_long);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* tone_burst_marker_detector.f */
rtl/tbmd_pkg.sv
rtl/tbmd_cfg.sv
rtl/tbmd_seq.sv
rtl/tbmd_dp.sv
rtl/tone_burst_marker_detector.sv
bench/tone_burst_marker_detector_tb.sv
